[src/bbd_pkg.sv]
// ----------------------------------------------------------------------------
// bbd_pkg: shared types and constants
// Word layouts, register indexes, color codes and the pipeline control record
// used by the bilinear Bayer demosaic core.
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int OUT_W    = 18;     // RGB words, two fraction bits
    localparam int POS_W    = 12;     // pixel row / column
    localparam int RAW_W    = 16;     // raw sample field
    localparam int CFG_W    = 13;     // widest config register
    localparam int CFA_W    = 8;
    localparam int ROW_W    = 12;     // row counter, frames up to 4096 lines
    localparam int HGT_W    = 13;     // row arithmetic with carry room

    localparam logic [HGT_W-1:0] HEIGHT_CAP = 13'd4096;
    localparam logic [CFG_W-1:0] DIM_MIN    = 13'd3;

    localparam logic [CFG_W-1:0] WIDTH_RST   = 13'd4096;
    localparam logic [CFG_W-1:0] HEIGHT_RST  = 13'd4096;
    localparam logic [CFA_W-1:0] CFA_RST     = 8'd148;

    // config register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CFA_PATTERN  = 2'd2;

    // CFA color codes (odd codes are green)
    localparam logic [1:0] CFA_RED  = 2'd0;
    localparam logic [1:0] CFA_BLUE = 2'd2;

    // output buffer
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    typedef struct packed {
        logic [RAW_W-1:0] raw_sample;
        logic             frame_start;
    } t_raw_word;

    typedef struct packed {
        logic [OUT_W-1:0] red_value;
        logic [OUT_W-1:0] green_value;
        logic [OUT_W-1:0] blue_value;
        logic [POS_W-1:0] pixel_row;
        logic [POS_W-1:0] pixel_col;
        logic             frame_done;
    } t_rgb_word;

    // per-sample control carried down the pipe
    typedef struct packed {
        logic             emit;
        logic [POS_W-1:0] pix_row;
        logic [POS_W-1:0] pix_col;
        logic [1:0]       color;
        logic             blue_row;
        logic             done;
    } t_pix_ctrl;

endpackage

[src/bbd_stream_if.sv]
// ----------------------------------------------------------------------------
// bbd_stream_if: valid/ready stream channel
// One word moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bbd_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

[src/bayer_bilinear_demosaic_core.sv]
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_core: streaming bilinear Bayer demosaic
// Raw raster samples in, full RGB of interior pixels out.
// ----------------------------------------------------------------------------
// Takes one raw word per clock while i_pix.ready is high and returns the RGB
// word of the pixel one row up and one column left of each newest sample, for
// interior pixels only (no border pixels are emitted). Position and line
// store address are worked out ahead of the accepting edge and the line store
// read lands on it; the window update follows, and the interpolated word then
// enters the output buffer that drives o_rgb. Sustained rate is one word per
// clock while o_rgb.ready stays high, set by the single line-store memory,
// which takes one read and one write-back per word. i_pix.ready falls only
// when the output buffer plus the words in the pipe would fill its FIFO_DEPTH
// entries, i.e. when the consumer holds o_rgb.ready low. frame_start puts a
// sample at row 0, column 0; frames also follow back to back without it. The
// user must write the registers (width, height, CFA pattern) through i_cfg_*
// only while the core is idle; the core does not enforce this. Out-of-range
// widths/heights are clamped to 3..MAX_LINE and 3..4096. The line store has
// no reset; its first two lines are filled by the frame.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_core #(
    parameter int MAX_LINE    = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [bbd_pkg::CFG_W-1:0]  i_cfg_data,
    bbd_stream_if.sink                 i_pix,
    bbd_stream_if.source               o_rgb
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CNT_W = $clog2(MAX_LINE);            // column / address
    localparam int WID_W = CNT_W + 1;
    localparam int CMP_W = (WID_W > bbd_pkg::CFG_W) ? WID_W : bbd_pkg::CFG_W;
    localparam int EXT_W = (SB > bbd_pkg::RAW_W) ? SB : bbd_pkg::RAW_W;
    localparam logic [CMP_W-1:0] LINE_CAP = CMP_W'(MAX_LINE);

    // ---------------- configuration registers ----------------
    logic [bbd_pkg::CFG_W-1:0] r_frame_width;
    logic [bbd_pkg::CFG_W-1:0] r_frame_height;
    logic [bbd_pkg::CFA_W-1:0] r_cfa_pattern;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bbd_pkg::WIDTH_RST;
            r_frame_height <= bbd_pkg::HEIGHT_RST;
            r_cfa_pattern  <= bbd_pkg::CFA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bbd_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                bbd_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                bbd_pkg::CFG_CFA_PATTERN:  r_cfa_pattern  <= i_cfg_data[bbd_pkg::CFA_W-1:0];
                default: ;  // unused index
            endcase
        end
    end

    // clamped frame size
    logic [CMP_W-1:0]          w_eff;
    logic [bbd_pkg::HGT_W-1:0] h_eff;

    always_comb begin
        priority if (CMP_W'(r_frame_width) < CMP_W'(bbd_pkg::DIM_MIN)) begin
            w_eff = CMP_W'(bbd_pkg::DIM_MIN);
        end else if (CMP_W'(r_frame_width) > LINE_CAP) begin
            w_eff = LINE_CAP;
        end else begin
            w_eff = CMP_W'(r_frame_width);
        end
        priority if (r_frame_height < bbd_pkg::DIM_MIN) begin
            h_eff = bbd_pkg::DIM_MIN;
        end else if (r_frame_height > bbd_pkg::HEIGHT_CAP) begin
            h_eff = bbd_pkg::HEIGHT_CAP;
        end else begin
            h_eff = r_frame_height;
        end
    end

    // ---------------- stage A: position, line store address ----------------
    logic [CNT_W-1:0]          r_col;     // position of the next sample
    logic [bbd_pkg::ROW_W-1:0] r_row;

    logic                      accept;
    logic [CMP_W-1:0]          col_a, col_b, col_n;
    logic [bbd_pkg::HGT_W-1:0] row_a, row_b, row_c, row_n;
    logic [SB-1:0]             smp_a;
    logic [EXT_W-1:0]          raw_ext;
    logic [bbd_pkg::FIFO_AW:0] fifo_count;
    logic                      r_s1_valid;
    logic                      r_s2_valid;
    bbd_pkg::t_pix_ctrl        ctrl_a;
    logic [bbd_pkg::HGT_W-1:0] pr_a;
    logic [CMP_W-1:0]          pc_a;
    logic [3:0]                site_a;
    logic [1:0]                site_blue0, site_blue1;

    // credit: buffer plus words in the pipe never exceed the buffer depth
    assign i_pix.ready = (bbd_pkg::FIFO_AW+1)'(fifo_count
                         + (bbd_pkg::FIFO_AW+1)'(r_s1_valid)
                         + (bbd_pkg::FIFO_AW+1)'(r_s2_valid))
                         < (bbd_pkg::FIFO_AW+1)'(bbd_pkg::FIFO_DEPTH);
    assign accept  = i_pix.valid && i_pix.ready;
    assign raw_ext = EXT_W'(i_pix.payload.raw_sample);
    assign smp_a   = raw_ext[SB-1:0];

    always_comb begin
        col_a = i_pix.payload.frame_start ? '0 : CMP_W'(r_col);
        row_a = i_pix.payload.frame_start ? '0 : bbd_pkg::HGT_W'(r_row);
        // column left over from a larger width wraps to the next row
        if (col_a >= w_eff) begin
            col_b = '0;
            row_b = row_a + 1'b1;
        end else begin
            col_b = col_a;
            row_b = row_a;
        end
        row_c = (row_b >= h_eff) ? '0 : row_b;

        // advance for the next sample
        col_n = col_b + 1'b1;
        row_n = row_c;
        if (col_n >= w_eff) begin
            col_n = '0;
            row_n = row_c + 1'b1;
            if (row_n >= h_eff) begin
                row_n = '0;
            end
        end

        pr_a = row_c - 1'b1;
        pc_a = col_b - 1'b1;
        site_a     = {pr_a[0], pc_a[0], 2'b00};
        site_blue0 = {pr_a[0], 1'b0};
        site_blue1 = {pr_a[0], 1'b1};

        ctrl_a.emit     = (row_c >= bbd_pkg::HGT_W'(2)) && (col_b >= CMP_W'(2));
        ctrl_a.pix_row  = pr_a[bbd_pkg::POS_W-1:0];
        ctrl_a.pix_col  = pc_a[bbd_pkg::POS_W-1:0];
        ctrl_a.color    = 2'(r_cfa_pattern >> site_a[3:1]);
        ctrl_a.blue_row = (2'(r_cfa_pattern >> {site_blue0, 1'b0}) == bbd_pkg::CFA_BLUE)
                       || (2'(r_cfa_pattern >> {site_blue1, 1'b0}) == bbd_pkg::CFA_BLUE);
        ctrl_a.done     = (row_c == h_eff - 1'b1) && (col_b == w_eff - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= col_n[CNT_W-1:0];
            r_row <= row_n[bbd_pkg::ROW_W-1:0];
        end
    end

    // ---------------- stage 1: line store read, window shift ----------------
    logic [SB-1:0]      ls_upper;
    logic [SB-1:0]      ls_lower;
    logic [SB-1:0]      r_s1_smp;
    bbd_pkg::t_pix_ctrl r_s1_ctrl;
    logic [SB-1:0]      r_win [9];
    bbd_pkg::t_pix_ctrl r_s2_ctrl;

    bbd_line_mem #(
        .SB    (SB),
        .DEPTH (MAX_LINE),
        .AW    (CNT_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (col_b[CNT_W-1:0]),
        .i_sample  (smp_a),
        .o_upper   (ls_upper),
        .o_lower   (ls_lower)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_smp  <= smp_a;
            r_s1_ctrl <= ctrl_a;
        end
        if (r_s1_valid) begin
            r_s2_ctrl <= r_s1_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid && r_s1_ctrl.emit;
            if (r_s1_valid) begin
                // rows top to bottom: upper line, lower line, new sample
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= ls_upper;
                r_win[5] <= ls_lower;
                r_win[8] <= r_s1_smp;
            end
        end
    end

    // ---------------- stage 2: interpolation into the output buffer ----------------
    bbd_pkg::t_rgb_word s2_word;

    bbd_interp #(
        .SB (SB)
    ) u_interp (
        .i_win  (r_win),
        .i_ctrl (r_s2_ctrl),
        .o_word (s2_word)
    );

    bbd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_word  (s2_word),
        .o_count (fifo_count),
        .o_rgb   (o_rgb)
    );

    // ---------------- assertions ----------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(fifo_count) + 32'(r_s1_valid) + 32'(r_s2_valid)) <= bbd_pkg::FIFO_DEPTH)
        else $error("output buffer credit exceeded");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (32'(fifo_count) < bbd_pkg::FIFO_DEPTH))
        else $error("push into full output buffer");

    a_s2_follows_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s2_valid) |-> $past(r_s1_valid))
        else $error("interpolation stage valid without line store stage");

endmodule

[src/bbd_line_mem.sv]
// ----------------------------------------------------------------------------
// bbd_line_mem: two-line store
// One synchronous memory holds {upper, lower} per column. Read is issued at
// accept, the write-back of {lower, sample} follows in the next cycle, with
// forwarding when the next read hits the column being written.
// ----------------------------------------------------------------------------
module bbd_line_mem #(
    parameter int SB    = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [SB-1:0] i_sample,
    output logic [SB-1:0] o_upper,
    output logic [SB-1:0] o_lower
);

    logic [2*SB-1:0] r_mem [DEPTH];
    logic [2*SB-1:0] r_rd;

    logic            r_s1_valid;
    logic [AW-1:0]   r_s1_addr;
    logic [SB-1:0]   r_s1_smp;
    logic            r_fwd;
    logic [2*SB-1:0] r_fwd_data;
    logic [2*SB-1:0] wr_data;
    logic            n_fwd;

    // entry in flight this cycle
    assign o_upper = r_fwd ? r_fwd_data[2*SB-1:SB] : r_rd[2*SB-1:SB];
    assign o_lower = r_fwd ? r_fwd_data[SB-1:0]    : r_rd[SB-1:0];
    assign wr_data = {o_lower, r_s1_smp};
    assign n_fwd   = r_s1_valid && (r_s1_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem[r_s1_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= i_rd_en;
            if (i_rd_en) begin
                r_fwd <= n_fwd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_s1_addr  <= i_rd_addr;
            r_s1_smp   <= i_sample;
            r_fwd_data <= wr_data;
        end
    end

endmodule

[src/bbd_interp.sv]
// ----------------------------------------------------------------------------
// bbd_interp: bilinear interpolation
// Builds the RGB word of the window center from the 3x3 neighbourhood.
// ----------------------------------------------------------------------------
module bbd_interp #(
    parameter int SB = 16
) (
    input  logic [SB-1:0]       i_win [9],
    input  bbd_pkg::t_pix_ctrl  i_ctrl,
    output bbd_pkg::t_rgb_word  o_word
);

    localparam int SW = SB + 2;

    logic [SW-1:0] center;
    logic [SW-1:0] horiz;
    logic [SW-1:0] vert;
    logic [SW-1:0] ortho;
    logic [SW-1:0] diag;
    logic [SW-1:0] red;
    logic [SW-1:0] green;
    logic [SW-1:0] blue;

    always_comb begin
        center = {i_win[4], 2'b00};
        horiz  = {(SW-1)'(i_win[3]) + (SW-1)'(i_win[5]), 1'b0};
        vert   = {(SW-1)'(i_win[1]) + (SW-1)'(i_win[7]), 1'b0};
        ortho  = SW'(i_win[1]) + SW'(i_win[3]) + SW'(i_win[5]) + SW'(i_win[7]);
        diag   = SW'(i_win[0]) + SW'(i_win[2]) + SW'(i_win[6]) + SW'(i_win[8]);

        if (i_ctrl.color[0]) begin
            green = center;
            red   = i_ctrl.blue_row ? vert  : horiz;
            blue  = i_ctrl.blue_row ? horiz : vert;
        end else if (i_ctrl.color == bbd_pkg::CFA_BLUE) begin
            blue  = center;
            green = ortho;
            red   = diag;
        end else begin
            red   = center;
            green = ortho;
            blue  = diag;
        end

        o_word.red_value   = bbd_pkg::OUT_W'(red);
        o_word.green_value = bbd_pkg::OUT_W'(green);
        o_word.blue_value  = bbd_pkg::OUT_W'(blue);
        o_word.pixel_row   = i_ctrl.pix_row;
        o_word.pixel_col   = i_ctrl.pix_col;
        o_word.frame_done  = i_ctrl.done;
    end

endmodule

[src/bbd_out_fifo.sv]
// ----------------------------------------------------------------------------
// bbd_out_fifo: output word buffer
// Small FIFO that decouples the pipeline from the output handshake.
// ----------------------------------------------------------------------------
module bbd_out_fifo (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  bbd_pkg::t_rgb_word       i_word,
    output logic [bbd_pkg::FIFO_AW:0] o_count,
    bbd_stream_if.source             o_rgb
);

    bbd_pkg::t_rgb_word             r_buf [bbd_pkg::FIFO_DEPTH];
    logic [bbd_pkg::FIFO_AW-1:0]    r_head;
    logic [bbd_pkg::FIFO_AW-1:0]    r_tail;
    logic [bbd_pkg::FIFO_AW:0]      r_count;
    logic                           pop;

    assign o_rgb.valid   = (r_count != '0);
    assign o_rgb.payload = r_buf[r_head];
    assign pop           = o_rgb.valid && o_rgb.ready;
    assign o_count       = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_tail] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (pop) begin
                r_head <= r_head + 1'b1;
            end
            r_count <= r_count + (bbd_pkg::FIFO_AW+1)'(i_push)
                               - (bbd_pkg::FIFO_AW+1)'(pop);
        end
    end

endmodule
